/* design/lcfr_pkg.sv */
// Shared constants and types of the length and checksum frame receiver.
package lcfr_pkg;

  localparam int MAX_FRAME_DEF = 40;
  localparam logic [7:0] MIN_LEN = 8'd5;
  localparam logic [5:0] MAX_LEN_RESET = 6'd20;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_ABORT    = 2'd3
  } status_t;

endpackage

/* design/length_checksum_frame_receiver.sv */
// Top level of the length-prefixed frame receiver with zero-sum checksum.
// Each received byte or gap beat is taken while the receiver hunts for a length
// byte or collects a frame; error and abort results are registered and appear
// on the output in the next cycle. When a frame passes its checks it is replayed
// from the frame store, whose single read port has a registered output, each byte
// going through a read state and then a send state, so the input is stalled
// until a good frame has been sent in full, longer when the output is stalled. A
// new beat is also held off while a finished result waits downstream.
module length_checksum_frame_receiver
  import lcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic [5:0] byte_index,
  output logic       last,
  output logic [1:0] status
);

  localparam int AW = $clog2(MAX_FRAME);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  lcfr_ctrl #(
    .MAX_FRAME(MAX_FRAME),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .byte_index(byte_index),
    .last(last),
    .status(status),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lcfr_ram #(
    .DEPTH(MAX_FRAME),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

/* design/lcfr_ram.sv */
// Frame byte store with one write port and one registered read port.
module lcfr_ram
  import lcfr_pkg::*;
#(
  parameter int DEPTH = MAX_FRAME_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/lcfr_ctrl.sv */
// Sequencer that hunts lengths, accumulates frames and replays good frames.
module lcfr_ctrl
  import lcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int AW = $clog2(MAX_FRAME)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  input  logic [7:0]    rx_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    frame_byte,
  output logic [5:0]    byte_index,
  output logic          last,
  output logic [1:0]    status,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t      state;
  logic [5:0]  max_len;
  logic        in_frame;
  logic [5:0]  exp_len;
  logic [5:0]  cnt;
  logic [7:0]  sum;
  logic        ok1;
  logic        ok2;
  logic [AW-1:0] idx;

  logic        out_free;
  logic        accept;
  logic [7:0]  limit;
  logic        len_ok;
  logic [5:0]  cnt_next;
  logic [7:0]  sum_next;
  logic        idx_last;
  logic        emit;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept = in_valid && !in_stall;

  assign limit = ({2'b00, max_len} > 8'(MAX_FRAME)) ? 8'(MAX_FRAME) : {2'b00, max_len};
  assign len_ok = (rx_byte >= MIN_LEN) && (rx_byte <= limit);
  assign cnt_next = cnt + 6'd1;
  assign sum_next = sum + rx_byte;
  assign idx_last = (6'(idx) + 6'd1) == exp_len;

  assign emit = accept ? (kind ? in_frame
                               : (in_frame && (cnt_next >= exp_len)
                                  && (!(ok1 && ok2) || (sum_next != 8'd0))))
                       : ((state == S_SEND) && out_free);

  assign wr_en = accept && !kind && (in_frame ? ({1'b0, cnt} < 7'(MAX_FRAME)) : len_ok);
  assign wr_addr = in_frame ? cnt[AW-1:0] : '0;
  assign wr_data = rx_byte;
  assign rd_addr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_len <= MAX_LEN_RESET;
      in_frame <= 1'b0;
      exp_len <= '0;
      cnt <= '0;
      sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind) begin
              if (in_frame) begin
                frame_byte <= 8'd0;
                byte_index <= cnt;
                last <= 1'b1;
                status <= ST_ABORT;
                in_frame <= 1'b0;
                cnt <= '0;
                sum <= '0;
              end
            end else if (!in_frame) begin
              if (len_ok) begin
                exp_len <= rx_byte[5:0];
                cnt <= 6'd1;
                sum <= rx_byte;
                in_frame <= 1'b1;
              end
            end else begin
              if (cnt == 6'd1) begin
                ok1 <= (rx_byte == 8'd0);
              end
              if (cnt == 6'd2) begin
                ok2 <= (rx_byte == 8'd1);
              end
              if (cnt_next >= exp_len) begin
                in_frame <= 1'b0;
                cnt <= '0;
                sum <= '0;
                if (!(ok1 && ok2) || sum_next != 8'd0) begin
                  frame_byte <= 8'd0;
                  byte_index <= 6'd0;
                  last <= 1'b1;
                  status <= (!(ok1 && ok2)) ? ST_BAD_ADDR : ST_BAD_SUM;
                end else begin
                  idx <= '0;
                  state <= S_READ;
                end
              end else begin
                cnt <= cnt_next;
                sum <= sum_next;
              end
            end
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            frame_byte <= rd_data;
            byte_index <= 6'(idx);
            last <= idx_last;
            status <= ST_GOOD;
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/lcfr_checker.sv */
// Port-level checks of the frame receiver and their binding to the top level.
module lcfr_port_props
  import lcfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] frame_byte,
  input logic [5:0] byte_index,
  input logic       last,
  input logic [1:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_index)
      && $stable(last) && $stable(status))
    else $error("Stalled output beat changed.");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("Input taken while a result was waiting.");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_GOOD |-> last && frame_byte == 8'd0)
    else $error("Error or abort beat is malformed.");

  a_short_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_GOOD && byte_index < 6'd4 |-> !last)
    else $error("Good frame ended too early.");

endmodule

bind length_checksum_frame_receiver lcfr_port_props u_lcfr_port_props (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .frame_byte(frame_byte),
  .byte_index(byte_index),
  .last(last),
  .status(status)
);
